// ===== src/homography_warp_source_address_top_assert.svh =====
// Assertion macros used by the checker file hwsa_checker.sv.
`ifndef HOMOGRAPHY_WARP_SOURCE_ADDRESS_TOP_ASSERT_SVH
`define HOMOGRAPHY_WARP_SOURCE_ADDRESS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HWSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HWSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hwsa_pkg.sv =====
`default_nettype none
package hwsa_pkg;

    localparam int OUT_DIM_MAX_DEF = 2048;
    localparam int SRC_DIM_MAX_DEF = 4096;

    localparam int COEF_W     = 32;
    localparam int FRAC_W     = 20;
    localparam int IN_W       = 11;
    localparam int OUT_W      = 12;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PROD_W     = 44;
    localparam int SUM_W      = 48;

    localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 13'd1280;
    localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 13'd720;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H00_H01    = 3'd0,
        CFG_H02_H10    = 3'd1,
        CFG_H11_H12    = 3'd2,
        CFG_H20_H21    = 3'd3,
        CFG_SRC_WIDTH  = 3'd4,
        CFG_SRC_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] h00;
        logic signed [COEF_W-1:0] h01;
        logic signed [COEF_W-1:0] h02;
        logic signed [COEF_W-1:0] h10;
        logic signed [COEF_W-1:0] h11;
        logic signed [COEF_W-1:0] h12;
        logic signed [COEF_W-1:0] h20;
        logic signed [COEF_W-1:0] h21;
        logic [DIM_W-1:0]         src_width;
        logic [DIM_W-1:0]         src_height;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] num;
        logic [SUM_W-1:0] den;
        logic             neg;
        logic             ovf;
    } t_div_in;

    function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        r = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/hwsa_cfg.sv =====
`default_nettype none
module hwsa_cfg
    import hwsa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_H00_H01: begin
                    n_cfg.h00 = i_cfg_data[31:0];
                    n_cfg.h01 = i_cfg_data[63:32];
                end
                CFG_H02_H10: begin
                    n_cfg.h02 = i_cfg_data[31:0];
                    n_cfg.h10 = i_cfg_data[63:32];
                end
                CFG_H11_H12: begin
                    n_cfg.h11 = i_cfg_data[31:0];
                    n_cfg.h12 = i_cfg_data[63:32];
                end
                CFG_H20_H21: begin
                    n_cfg.h20 = i_cfg_data[31:0];
                    n_cfg.h21 = i_cfg_data[63:32];
                end
                CFG_SRC_WIDTH:  n_cfg.src_width  = i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: n_cfg.src_height = i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg            <= '0;
            r_cfg.src_width  <= SRC_WIDTH_RST;
            r_cfg.src_height <= SRC_HEIGHT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== src/hwsa_proj.sv =====
`default_nettype none
module hwsa_proj
    import hwsa_pkg::*;
#(
    parameter int OUT_DIM_MAX = OUT_DIM_MAX_DEF,
    parameter int QW          = 13
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  t_cfg                 i_cfg,
    input  wire logic [IN_W-1:0] i_col,
    input  wire logic [IN_W-1:0] i_row,
    output t_div_in              o_x,
    output t_div_in              o_y,
    output logic                 o_ok
);

    localparam int CW = SUM_W + QW;

    logic signed [PROD_W-1:0] r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    logic                     r_in1;
    logic signed [SUM_W-1:0]  r_x, r_y, r_z;
    logic                     r_in2;
    t_div_in                  r_xd, r_yd;
    logic                     r_ok;

    logic signed [PROD_W-1:0] n_ic, n_jr;
    logic                     n_in1;
    logic signed [SUM_W-1:0]  n_x, n_y, n_z;
    logic [SUM_W-1:0]         n_az, n_ax, n_ay;
    t_div_in                  n_xd, n_yd;

    always_comb begin
        n_ic  = PROD_W'($signed({1'b0, i_col}));
        n_jr  = PROD_W'($signed({1'b0, i_row}));
        n_in1 = (32'(i_col) < 32'(OUT_DIM_MAX)) && (32'(i_row) < 32'(OUT_DIM_MAX));

        n_x = SUM_W'(r_p00) + SUM_W'(r_p01) + SUM_W'(i_cfg.h02);
        n_y = SUM_W'(r_p10) + SUM_W'(r_p11) + SUM_W'(i_cfg.h12);
        n_z = SUM_W'(r_p20) + SUM_W'(r_p21) + (SUM_W'(1) <<< FRAC_W);

        n_az = mag(r_z);
        n_ax = mag(r_x);
        n_ay = mag(r_y);

        n_xd.num = (n_ax << 1) + n_az;
        n_xd.den = n_az << 1;
        n_xd.neg = r_x[SUM_W-1] ^ r_z[SUM_W-1];
        n_xd.ovf = CW'(n_xd.num) >= (CW'(n_xd.den) << QW);

        n_yd.num = (n_ay << 1) + n_az;
        n_yd.den = n_az << 1;
        n_yd.neg = r_y[SUM_W-1] ^ r_z[SUM_W-1];
        n_yd.ovf = CW'(n_yd.num) >= (CW'(n_yd.den) << QW);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= PROD_W'(i_cfg.h00) * n_ic;
            r_p01 <= PROD_W'(i_cfg.h01) * n_jr;
            r_p10 <= PROD_W'(i_cfg.h10) * n_ic;
            r_p11 <= PROD_W'(i_cfg.h11) * n_jr;
            r_p20 <= PROD_W'(i_cfg.h20) * n_ic;
            r_p21 <= PROD_W'(i_cfg.h21) * n_jr;
            r_in1 <= n_in1;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_in2 <= r_in1;
            r_xd  <= n_xd;
            r_yd  <= n_yd;
            r_ok  <= r_in2 && (r_z != '0);
        end
    end

    assign o_x  = r_xd;
    assign o_y  = r_yd;
    assign o_ok = r_ok;

endmodule
`default_nettype wire

// ===== src/hwsa_div.sv =====
`default_nettype none
module hwsa_div
    import hwsa_pkg::*;
#(
    parameter int QW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  t_div_in            i_d,
    output logic [QW-1:0]      o_q,
    output logic               o_ovf,
    output logic               o_neg
);

    localparam int CW = SUM_W + QW;

    logic [SUM_W-1:0] w_rem [QW+1];
    logic [SUM_W-1:0] w_den [QW+1];
    logic [QW-1:0]    w_q   [QW+1];
    logic             w_ovf [QW+1];
    logic             w_neg [QW+1];

    assign w_rem[0] = i_d.num;
    assign w_den[0] = i_d.den;
    assign w_q[0]   = '0;
    assign w_ovf[0] = i_d.ovf;
    assign w_neg[0] = i_d.neg;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;

        logic [SUM_W-1:0] r_rem, r_den;
        logic [QW-1:0]    r_q;
        logic             r_ovf, r_neg;
        logic [CW-1:0]    n_sh;
        logic             n_ge;
        logic [SUM_W-1:0] n_rem;
        logic [QW-1:0]    n_q;

        always_comb begin
            n_sh  = CW'(w_den[s]) << B;
            n_ge  = CW'(w_rem[s]) >= n_sh;
            n_rem = n_ge ? SUM_W'(CW'(w_rem[s]) - n_sh) : w_rem[s];
            n_q   = n_ge ? (w_q[s] | (QW'(1) << B)) : w_q[s];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_den <= w_den[s];
                r_q   <= n_q;
                r_ovf <= w_ovf[s];
                r_neg <= w_neg[s];
            end
        end

        assign w_rem[s+1] = r_rem;
        assign w_den[s+1] = r_den;
        assign w_q[s+1]   = r_q;
        assign w_ovf[s+1] = r_ovf;
        assign w_neg[s+1] = r_neg;
    end

    assign o_q   = w_q[QW];
    assign o_ovf = w_ovf[QW];
    assign o_neg = w_neg[QW];

endmodule
`default_nettype wire

// ===== src/homography_warp_source_address_top.sv =====
// Homography source-address generator: one output-plane pixel in, one source
// address out, at one transaction per clock while o_stall is low. QW is
// ceil(log2(SRC_DIM_MAX)) + 1 (13 at the default 4096); the pipeline holds
// the three projection stages and the restoring divider, which resolves one
// quotient bit per stage. An output register plus one skid entry decouple the
// result side: input continues while one result waits, until the skid is full.
// Write coefficient and size registers only while the block is empty.
`default_nettype none
module homography_warp_source_address_top
    import hwsa_pkg::*;
#(
    parameter int OUT_DIM_MAX = OUT_DIM_MAX_DEF,
    parameter int SRC_DIM_MAX = SRC_DIM_MAX_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [IN_W-1:0]       i_out_col,
    input  wire logic [IN_W-1:0]       i_out_row,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [OUT_W-1:0]           o_src_x,
    output logic [OUT_W-1:0]           o_src_y,
    output logic                       o_in_range,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = $clog2(SRC_DIM_MAX) + 1;
    localparam int NP = 3 + QW;
    localparam int LW = DIM_W + 1;
    localparam logic [LW-1:0] SRC_LIM = LW'(SRC_DIM_MAX);

    typedef struct packed {
        logic [OUT_W-1:0] src_x;
        logic [OUT_W-1:0] src_y;
        logic             in_range;
    } t_res;

    t_cfg    w_cfg;
    t_div_in w_xd, w_yd;
    logic    w_ok;
    logic    w_en;
    logic [QW-1:0] w_qx, w_qy;
    logic    w_ovfx, w_ovfy, w_negx, w_negy;

    logic [NP-1:0] r_vld;
    logic [QW-1:0] r_okp;
    logic          r_ovld, r_skid_vld;
    t_res          r_out, r_skid;

    logic [LW-1:0] n_wlim, n_hlim;
    logic          n_xok, n_yok;
    t_res          n_res;
    logic          n_pop, n_inc;

    assign o_cfg_ready = 1'b1;

    hwsa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;

    hwsa_proj #(.OUT_DIM_MAX(OUT_DIM_MAX), .QW(QW)) u_proj (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (w_cfg),
        .i_col (i_out_col),
        .i_row (i_out_row),
        .o_x   (w_xd),
        .o_y   (w_yd),
        .o_ok  (w_ok)
    );

    hwsa_div #(.QW(QW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_xd),
        .o_q   (w_qx),
        .o_ovf (w_ovfx),
        .o_neg (w_negx)
    );

    hwsa_div #(.QW(QW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_yd),
        .o_q   (w_qy),
        .o_ovf (w_ovfy),
        .o_neg (w_negy)
    );

    always_comb begin
        n_wlim = (LW'(w_cfg.src_width) < SRC_LIM) ? LW'(w_cfg.src_width) : SRC_LIM;
        n_hlim = (LW'(w_cfg.src_height) < SRC_LIM) ? LW'(w_cfg.src_height) : SRC_LIM;
        n_xok  = !w_ovfx && !(w_negx && (w_qx != '0)) && (32'(w_qx) < 32'(n_wlim));
        n_yok  = !w_ovfy && !(w_negy && (w_qy != '0)) && (32'(w_qy) < 32'(n_hlim));
        n_res.in_range = r_okp[QW-1] && n_xok && n_yok;
        n_res.src_x    = n_res.in_range ? OUT_W'(w_qx) : '0;
        n_res.src_y    = n_res.in_range ? OUT_W'(w_qy) : '0;
        n_pop = r_ovld && !i_stall;
        n_inc = w_en && r_vld[NP-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_okp <= {r_okp[QW-2:0], w_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_ovld     <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[NP-2:0], i_valid};
            end
            if (r_skid_vld) begin
                if (n_pop) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (n_inc) begin
                if (!r_ovld || n_pop) begin
                    r_ovld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (n_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (n_pop) begin
                r_out <= r_skid;
            end
        end else if (n_inc) begin
            if (!r_ovld || n_pop) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_valid    = r_ovld;
    assign o_src_x    = r_out.src_x;
    assign o_src_y    = r_out.src_y;
    assign o_in_range = r_out.in_range;

endmodule
`default_nettype wire

// ===== src/hwsa_checker.sv =====
`default_nettype none
`include "homography_warp_source_address_top_assert.svh"
module hwsa_checker
    import hwsa_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_stall,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire logic [OUT_W-1:0] o_src_x,
    input wire logic [OUT_W-1:0] o_src_y,
    input wire logic             o_in_range
);

    `HWSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_src_x) && $stable(o_src_y) && $stable(o_in_range), "result changed while stalled")
    `HWSA_ASSERT_NOW(a_black_zero, i_clk, i_rst_n, o_valid && !o_in_range, (o_src_x == '0) && (o_src_y == '0), "out-of-range result carries nonzero address")
    `HWSA_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, o_valid, "input stalled with no result pending")
    `HWSA_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, $rose(o_stall), $past(o_valid && i_stall), "input stall rose without a stalled result")

endmodule

bind homography_warp_source_address_top hwsa_checker u_hwsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_src_x    (o_src_x),
    .o_src_y    (o_src_y),
    .o_in_range (o_in_range)
);
`default_nettype wire
